@@ rtl/ps2mc_pkg.sv @@
package ps2mc_pkg;

	// configuration register width and index
	localparam int REG_W     = 12;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_X = 1'b0,
		CFG_MAX_Y = 1'b1
	} cfg_reg_t;

	localparam logic [REG_W-1:0] MAX_X_RESET = 12'd319;
	localparam logic [REG_W-1:0] MAX_Y_RESET = 12'd199;
	localparam logic [REG_W-1:0] POS_X_RESET = 12'd160;
	localparam logic [REG_W-1:0] POS_Y_RESET = 12'd100;

	// header byte bits
	localparam int HDR_LEFT_BIT  = 0;
	localparam int HDR_VALID_BIT = 3;
	localparam int HDR_XSIGN_BIT = 4;
	localparam int HDR_YSIGN_BIT = 5;

	// place of the next mouse byte within a packet
	typedef enum logic [1:0] {
		POS_HEADER = 2'd0,
		POS_XDELTA = 2'd1,
		POS_YDELTA = 2'd2
	} byte_pos_t;

endpackage

@@ rtl/ps2mc_clamp.sv @@
module ps2mc_clamp #(
	parameter int COORD_WIDTH = 12
) (
	input  logic [COORD_WIDTH-1:0]       pos,
	input  logic [7:0]                   delta_byte,
	input  logic                         delta_neg,
	input  logic                         subtract,
	input  logic [ps2mc_pkg::REG_W-1:0]  limit,
	output logic [COORD_WIDTH-1:0]       result
);
	import ps2mc_pkg::*;

	localparam int AW = ((COORD_WIDTH > REG_W) ? COORD_WIDTH : REG_W) + 2;

	logic signed [AW-1:0] pos_a;
	logic signed [AW-1:0] delta_a;
	logic signed [AW-1:0] sum_a;
	logic signed [AW-1:0] lim_raw;
	logic signed [AW-1:0] coord_mask;
	logic signed [AW-1:0] lim_a;
	logic signed [AW-1:0] clamped;

	always_comb begin
		pos_a      = {{(AW-COORD_WIDTH){1'b0}}, pos};
		// nine-bit delta, sign taken from the header
		delta_a    = {{(AW-9){delta_neg}}, delta_neg, delta_byte};
		lim_raw    = {{(AW-REG_W){1'b0}}, limit};
		coord_mask = {{(AW-COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};
		lim_a      = (lim_raw > coord_mask) ? coord_mask : lim_raw;
		sum_a      = subtract ? (pos_a - delta_a) : (pos_a + delta_a);
		if (sum_a < 0) begin
			clamped = '0;
		end else if (sum_a > lim_a) begin
			clamped = lim_a;
		end else begin
			clamped = sum_a;
		end
		result = clamped[COORD_WIDTH-1:0];
	end

endmodule

@@ rtl/ps2_mouse_packet_cursor.sv @@
// An accepted poll item passes the input register, then the result register, to out_valid.
// Throughput: one item per cycle unless the output stalls; the packet counter and cursor
// update as an item leaves the input register, so the next item sees them in the following cycle.
// Reset (arst_n low, asynchronous): pipeline empty, packet counter at the header byte,
// cursor at column 160 / row 100, button released, limits at 319 / 199.
module ps2_mouse_packet_cursor #(
	parameter int COORD_WIDTH = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             data_ready,
	input  logic                             from_aux,
	input  logic [7:0]                       data_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             packet_done,
	output logic [ps2mc_pkg::REG_W-1:0]      cursor_x,
	output logic [ps2mc_pkg::REG_W-1:0]      cursor_y,
	output logic                             left_button,
	input  logic                             cfg_wen,
	input  logic [ps2mc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ps2mc_pkg::REG_W-1:0]      cfg_data
);
	import ps2mc_pkg::*;

	localparam int AW = ((COORD_WIDTH > REG_W) ? COORD_WIDTH : REG_W) + 2;
	localparam logic [COORD_WIDTH-1:0] RST_X = COORD_WIDTH'(POS_X_RESET);
	localparam logic [COORD_WIDTH-1:0] RST_Y = COORD_WIDTH'(POS_Y_RESET);

	// input register
	logic       valid_s1;
	logic       data_ready_s1;
	logic       from_aux_s1;
	logic [7:0] data_byte_s1;

	// result register
	logic                 valid_s2;
	logic                 packet_done_s2;
	logic [REG_W-1:0]     cursor_x_s2;
	logic [REG_W-1:0]     cursor_y_s2;
	logic                 left_button_s2;

	// block state
	byte_pos_t             byte_pos_q;
	byte_pos_t             byte_pos_d;
	logic [7:0]            header_q;
	logic [7:0]            xdelta_q;
	logic [COORD_WIDTH-1:0] pos_x_q;
	logic [COORD_WIDTH-1:0] pos_y_q;
	logic                  button_q;
	logic [REG_W-1:0]      max_x_q;
	logic [REG_W-1:0]      max_y_q;

	logic                  adv2;
	logic                  aux_byte;
	logic                  third_byte;
	logic                  pkt_ok;
	logic [COORD_WIDTH-1:0] new_x;
	logic [COORD_WIDTH-1:0] new_y;
	logic [AW-1:0]         next_x_ext;
	logic [AW-1:0]         next_y_ext;

	assign adv2     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv2;
	assign aux_byte = valid_s1 && data_ready_s1 && from_aux_s1;

	// packet position: next state
	always_comb begin
		byte_pos_d = byte_pos_q;
		if (aux_byte) begin
			case (byte_pos_q)
				POS_HEADER: byte_pos_d = POS_XDELTA;
				POS_XDELTA: byte_pos_d = POS_YDELTA;
				default:    byte_pos_d = POS_HEADER;
			endcase
		end
	end

	// packet position: outputs
	always_comb begin
		case (byte_pos_q)
			POS_HEADER: third_byte = 1'b0;
			POS_XDELTA: third_byte = 1'b0;
			default:    third_byte = aux_byte;
		endcase
		pkt_ok = third_byte && header_q[HDR_VALID_BIT];
	end

	ps2mc_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_x (
		.pos        (pos_x_q),
		.delta_byte (xdelta_q),
		.delta_neg  (header_q[HDR_XSIGN_BIT]),
		.subtract   (1'b0),
		.limit      (max_x_q),
		.result     (new_x)
	);

	// screen rows grow downwards: subtract Y
	ps2mc_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_y (
		.pos        (pos_y_q),
		.delta_byte (data_byte_s1),
		.delta_neg  (header_q[HDR_YSIGN_BIT]),
		.subtract   (1'b1),
		.limit      (max_y_q),
		.result     (new_y)
	);

	assign next_x_ext = AW'(pkt_ok ? new_x : pos_x_q);
	assign next_y_ext = AW'(pkt_ok ? new_y : pos_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_ready_s1 <= data_ready;
			from_aux_s1   <= from_aux;
			data_byte_s1  <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			packet_done_s2 <= pkt_ok;
			cursor_x_s2    <= next_x_ext[REG_W-1:0];
			cursor_y_s2    <= next_y_ext[REG_W-1:0];
			left_button_s2 <= pkt_ok ? header_q[HDR_LEFT_BIT] : button_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= POS_HEADER;
			header_q   <= '0;
			xdelta_q   <= '0;
			pos_x_q    <= RST_X;
			pos_y_q    <= RST_Y;
			button_q   <= 1'b0;
		end else if (adv2) begin
			byte_pos_q <= byte_pos_d;
			if (aux_byte && byte_pos_q == POS_HEADER) begin
				header_q <= data_byte_s1;
			end
			if (aux_byte && byte_pos_q == POS_XDELTA) begin
				xdelta_q <= data_byte_s1;
			end
			if (pkt_ok) begin
				pos_x_q  <= new_x;
				pos_y_q  <= new_y;
				button_q <= header_q[HDR_LEFT_BIT];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_MAX_X: max_x_q <= cfg_data;
				CFG_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid   = valid_s2;
	assign packet_done = packet_done_s2;
	assign cursor_x    = cursor_x_s2;
	assign cursor_y    = cursor_y_s2;
	assign left_button = left_button_s2;

endmodule

@@ rtl/ps2mc_checker.sv @@
module ps2mc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             packet_done,
	input logic [ps2mc_pkg::REG_W-1:0]      cursor_x,
	input logic [ps2mc_pkg::REG_W-1:0]      cursor_y,
	input logic                             left_button
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packet_done)
			&& $stable(cursor_x) && $stable(cursor_y) && $stable(left_button))
		else $error("result changed while stalled");

	// input side backs up only behind a stalled full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// an accepted item reaches the output through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("result missing two cycles after item");

	// a result without a packet repeats the previous cursor and button
	a_no_packet_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) ##1 (out_valid && !packet_done) |->
			cursor_x == $past(cursor_x) && cursor_y == $past(cursor_y)
			&& left_button == $past(left_button))
		else $error("cursor moved without a packet");

endmodule

bind ps2_mouse_packet_cursor ps2mc_checker u_ps2mc_checker (.*);
